>>> sv/mosaic_block_averager_core_macros.svh
// Assertion macros shared by the mosaic block averager RTL.
`ifndef MOSAIC_BLOCK_AVERAGER_CORE_MACROS_SVH
`define MOSAIC_BLOCK_AVERAGER_CORE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define MBA_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define MBA_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mba_pkg.sv
// Package with constants and types of the mosaic block averager.
`default_nettype none
package mba_pkg;
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_BLOCK = 64;
    localparam int MAX_HEIGHT = 4096;
    localparam int SLOT_W = $clog2(MAX_WIDTH);
    localparam int SUM_W = 20;
    localparam int CNT_W = 13;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int LANES = 4;

    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;
endpackage
`default_nettype wire

>>> sv/mosaic_block_averager_core.sv
// Mosaic block averager: per-block RGB floor averages over a pixel stream.
// One pixel item is taken at a time. A pixel that closes no block passes through accept,
// sum-store read and sum-store update. A pixel that closes a block then adds a pass of the
// radix-2 divider, which runs the three channel averages and the block row index side
// by side in four lanes, and then loads the output register. That load waits for as long
// as an earlier result waits stalled in the output register.
// While a result waits in the output register the next pixel is still accepted.
// Block column sums live in a 4096-entry memory that needs no clearing, since each
// block's first pixel overwrites its entry.
`default_nettype none
`include "mosaic_block_averager_core_macros.svh"
module mosaic_block_averager_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       avg_red,
    output logic [7:0]       avg_green,
    output logic [7:0]       avg_blue,
    output logic [11:0]      block_row,
    output logic [11:0]      block_col,
    output logic [12:0]      pixel_count,
    output logic             last_block,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    localparam int SW = mba_pkg::SUM_W;
    localparam int CW = mba_pkg::CNT_W;
    localparam logic [mba_pkg::DIV_CNT_W-1:0] DIV_LAST =
        mba_pkg::DIV_CNT_W'(mba_pkg::DIV_STEPS - 1);

    mba_pkg::state_t state_reg, state_next;

    logic [6:0]  block_size_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;

    logic [11:0] col_pos_reg;
    logic [11:0] row_pos_reg;
    logic [5:0]  row_in_band_reg;
    logic [5:0]  col_in_block_reg;
    logic [11:0] block_col_idx_reg;

    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [mba_pkg::SLOT_W-1:0] slot_reg;
    logic        first_reg;
    logic        emit_reg;
    logic        last_reg;
    logic [CW-1:0] count_reg;
    logic [11:0] row_snap_reg;
    logic [6:0]  bs_snap_reg;

    logic [3*SW-1:0] sum_mem [mba_pkg::MAX_WIDTH];
    logic [3*SW-1:0] rd_data_reg;

    logic [SW-1:0] quo_reg [mba_pkg::LANES];
    logic [CW-1:0] rem_reg [mba_pkg::LANES];
    logic [CW-1:0] dsr_reg [mba_pkg::LANES];
    logic [SW-1:0] quo_next [mba_pkg::LANES];
    logic [CW-1:0] rem_next [mba_pkg::LANES];
    logic [mba_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic        out_valid_reg;
    logic [7:0]  avg_red_reg, avg_green_reg, avg_blue_reg;
    logic [11:0] block_row_reg, block_col_reg;
    logic [12:0] pixel_count_reg;
    logic        last_block_reg;

    logic [6:0]  bs;
    logic [12:0] w;
    logic [12:0] h;
    logic        accept;
    logic        row_end, image_end, col_end, band_end;
    logic [13:0] count_prod;
    logic [SW-1:0] sum_r, sum_g, sum_b;
    logic        out_free;
    logic        div_phase;
    logic        out_held;
    logic [61:0] out_word;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != mba_pkg::ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (block_size_reg == 7'd0)
            bs = 7'd1;
        else if (block_size_reg > 7'(mba_pkg::MAX_BLOCK))
            bs = 7'(mba_pkg::MAX_BLOCK);
        else
            bs = block_size_reg;
        if (image_width_reg == 13'd0)
            w = 13'd1;
        else if (image_width_reg > 13'(mba_pkg::MAX_WIDTH))
            w = 13'(mba_pkg::MAX_WIDTH);
        else
            w = image_width_reg;
        if (image_height_reg == 13'd0)
            h = 13'd1;
        else if (image_height_reg > 13'(mba_pkg::MAX_HEIGHT))
            h = 13'(mba_pkg::MAX_HEIGHT);
        else
            h = image_height_reg;
    end

    assign row_end = ({1'b0, col_pos_reg} + 13'd1) >= w;
    assign image_end = ({1'b0, row_pos_reg} + 13'd1) >= h;
    assign col_end = row_end || (({1'b0, col_in_block_reg} + 7'd1) >= bs);
    assign band_end = image_end || (({1'b0, row_in_band_reg} + 7'd1) >= bs);
    assign count_prod = ({1'b0, col_in_block_reg} + 7'd1) *
                        ({1'b0, row_in_band_reg} + 7'd1);

    always_comb
    begin
        if (first_reg)
        begin
            sum_r = SW'(red_reg);
            sum_g = SW'(green_reg);
            sum_b = SW'(blue_reg);
        end
        else
        begin
            sum_r = rd_data_reg[3*SW-1:2*SW] + SW'(red_reg);
            sum_g = rd_data_reg[2*SW-1:SW] + SW'(green_reg);
            sum_b = rd_data_reg[SW-1:0] + SW'(blue_reg);
        end
    end

    always_comb
    begin
        logic [CW:0] trial;
        for (int i = 0; i < mba_pkg::LANES; i++)
        begin
            trial = {rem_reg[i], quo_reg[i][SW-1]};
            if (trial >= {1'b0, dsr_reg[i]})
            begin
                rem_next[i] = CW'(trial - {1'b0, dsr_reg[i]});
                quo_next[i] = {quo_reg[i][SW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[CW-1:0];
                quo_next[i] = {quo_reg[i][SW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mba_pkg::ST_IDLE:
                if (accept)
                    state_next = mba_pkg::ST_READ;
            mba_pkg::ST_READ:
                state_next = mba_pkg::ST_UPD;
            mba_pkg::ST_UPD:
                state_next = emit_reg ? mba_pkg::ST_DIV : mba_pkg::ST_IDLE;
            mba_pkg::ST_DIV:
                if (div_cnt_reg == DIV_LAST)
                    state_next = mba_pkg::ST_HOLD;
            mba_pkg::ST_HOLD:
                if (out_free)
                    state_next = mba_pkg::ST_IDLE;
            default:
                state_next = mba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mba_pkg::ST_IDLE;
            block_size_reg <= 7'd1;
            image_width_reg <= 13'd1;
            image_height_reg <= 13'd1;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_in_band_reg <= '0;
            col_in_block_reg <= '0;
            block_col_idx_reg <= '0;
            div_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mba_pkg::REG_BLOCK_SIZE:   block_size_reg <= cfg_data[6:0];
                    mba_pkg::REG_IMAGE_WIDTH:  image_width_reg <= cfg_data;
                    mba_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            if (accept)
            begin
                if (row_end)
                begin
                    col_pos_reg <= '0;
                    col_in_block_reg <= '0;
                    block_col_idx_reg <= '0;
                    if (image_end)
                    begin
                        row_pos_reg <= '0;
                        row_in_band_reg <= '0;
                    end
                    else
                    begin
                        row_pos_reg <= row_pos_reg + 12'd1;
                        row_in_band_reg <= band_end ? 6'd0 : row_in_band_reg + 6'd1;
                    end
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + 12'd1;
                    if (col_end)
                    begin
                        col_in_block_reg <= '0;
                        block_col_idx_reg <= block_col_idx_reg + 12'd1;
                    end
                    else
                    begin
                        col_in_block_reg <= col_in_block_reg + 6'd1;
                    end
                end
            end
            if (state_reg == mba_pkg::ST_UPD)
                div_cnt_reg <= '0;
            else if (state_reg == mba_pkg::ST_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (state_reg == mba_pkg::ST_HOLD && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg <= red;
            green_reg <= green;
            blue_reg <= blue;
            slot_reg <= block_col_idx_reg;
            first_reg <= (row_in_band_reg == 6'd0) && (col_in_block_reg == 6'd0);
            emit_reg <= col_end && band_end;
            last_reg <= row_end && image_end;
            count_reg <= count_prod[CW-1:0];
            row_snap_reg <= row_pos_reg;
            bs_snap_reg <= bs;
        end
        if (state_reg == mba_pkg::ST_READ)
            rd_data_reg <= sum_mem[slot_reg];
        if (state_reg == mba_pkg::ST_UPD)
        begin
            sum_mem[slot_reg] <= {sum_r, sum_g, sum_b};
            quo_reg[0] <= sum_r;
            quo_reg[1] <= sum_g;
            quo_reg[2] <= sum_b;
            quo_reg[3] <= SW'(row_snap_reg);
            for (int i = 0; i < mba_pkg::LANES; i++)
                rem_reg[i] <= '0;
            dsr_reg[0] <= count_reg;
            dsr_reg[1] <= count_reg;
            dsr_reg[2] <= count_reg;
            dsr_reg[3] <= CW'(bs_snap_reg);
        end
        else if (state_reg == mba_pkg::ST_DIV)
        begin
            for (int i = 0; i < mba_pkg::LANES; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (state_reg == mba_pkg::ST_HOLD && out_free)
        begin
            avg_red_reg <= (quo_reg[0] > SW'(255)) ? 8'd255 : quo_reg[0][7:0];
            avg_green_reg <= (quo_reg[1] > SW'(255)) ? 8'd255 : quo_reg[1][7:0];
            avg_blue_reg <= (quo_reg[2] > SW'(255)) ? 8'd255 : quo_reg[2][7:0];
            block_row_reg <= quo_reg[3][11:0];
            block_col_reg <= slot_reg;
            pixel_count_reg <= count_reg;
            last_block_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign avg_red = avg_red_reg;
    assign avg_green = avg_green_reg;
    assign avg_blue = avg_blue_reg;
    assign block_row = block_row_reg;
    assign block_col = block_col_reg;
    assign pixel_count = pixel_count_reg;
    assign last_block = last_block_reg;

    assign div_phase = (state_reg == mba_pkg::ST_DIV);
    assign out_held = out_valid_reg && out_stall;
    assign out_word = {avg_red_reg, avg_green_reg, avg_blue_reg, block_row_reg,
                       block_col_reg, pixel_count_reg, last_block_reg};

    `MBA_ASSERT_NEXT(a_accept_reads, accept, state_reg == mba_pkg::ST_READ, "No read after accept.")
    `MBA_ASSERT_SAME(a_div_bound, div_phase, div_cnt_reg <= DIV_LAST, "Divider overran.")
    `MBA_ASSERT_NEXT(a_held_result, out_held, $stable(out_word), "Held item changed.")
endmodule
`default_nettype wire

>>> sim/mosaic_block_averager_core_tb.sv
// Self-checking testbench of the mosaic block averager: directed and random images.
module mosaic_block_averager_core_tb;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_BUDGET = 1150;

    typedef struct packed {
        logic [7:0]  avg_red;
        logic [7:0]  avg_green;
        logic [7:0]  avg_blue;
        logic [11:0] block_row;
        logic [11:0] block_col;
        logic [12:0] pixel_count;
        logic        last_block;
    } block_avg_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  index;
        logic [12:0] data;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        known;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [11:0] block_row;
    logic [11:0] block_col;
    logic [12:0] pixel_count;
    logic        last_block;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    mosaic_block_averager_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .red(red), .green(green), .blue(blue),
        .out_valid(out_valid), .out_stall(out_stall),
        .avg_red(avg_red), .avg_green(avg_green), .avg_blue(avg_blue),
        .block_row(block_row), .block_col(block_col),
        .pixel_count(pixel_count), .last_block(last_block),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the block state.
    logic [6:0]  shadow_bs;
    logic [12:0] shadow_w;
    logic [12:0] shadow_h;
    logic [19:0] col_sum_r [mba_pkg::MAX_WIDTH];
    logic [19:0] col_sum_g [mba_pkg::MAX_WIDTH];
    logic [19:0] col_sum_b [mba_pkg::MAX_WIDTH];
    logic [11:0] pos_col;
    logic [11:0] pos_row;
    logic [5:0]  band_row;
    logic [5:0]  blk_col_off;
    logic [11:0] blk_col_idx;

    block_avg_t  pending_blocks[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          blocks_seen = 0;
    int          cfg_writes = 0;
    bit          calm = 0;
    bit          hold_request = 0;
    int          hold_left = 0;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] floor_avg(logic [19:0] sum, int unsigned cnt);
        int unsigned q;
        q = sum / cnt;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic bit average_pixel(input logic [7:0] r, g, b, output block_avg_t res);
        int unsigned bs;
        int unsigned w;
        int unsigned h;
        int unsigned cnt;
        int unsigned slot;
        bit row_end;
        bit image_end;
        bit col_end;
        bit band_end;
        bit emit;
        bs = clamp_cfg(shadow_bs, mba_pkg::MAX_BLOCK);
        w = clamp_cfg(shadow_w, mba_pkg::MAX_WIDTH);
        h = clamp_cfg(shadow_h, mba_pkg::MAX_HEIGHT);
        slot = blk_col_idx;
        row_end = (pos_col + 1 >= w);
        image_end = (pos_row + 1 >= h);
        col_end = row_end || (blk_col_off + 1 >= bs);
        band_end = image_end || (band_row + 1 >= bs);
        if (band_row == 0 && blk_col_off == 0)
        begin
            col_sum_r[slot] = r;
            col_sum_g[slot] = g;
            col_sum_b[slot] = b;
        end
        else
        begin
            col_sum_r[slot] = col_sum_r[slot] + r;
            col_sum_g[slot] = col_sum_g[slot] + g;
            col_sum_b[slot] = col_sum_b[slot] + b;
        end
        emit = col_end && band_end;
        res = '0;
        if (emit)
        begin
            cnt = (blk_col_off + 1) * (band_row + 1);
            res.avg_red = floor_avg(col_sum_r[slot], cnt);
            res.avg_green = floor_avg(col_sum_g[slot], cnt);
            res.avg_blue = floor_avg(col_sum_b[slot], cnt);
            res.block_row = 12'(pos_row / bs);
            res.block_col = blk_col_idx;
            res.pixel_count = 13'(cnt);
            res.last_block = row_end && image_end;
        end
        if (row_end)
        begin
            pos_col = 0;
            blk_col_off = 0;
            blk_col_idx = 0;
            if (image_end)
            begin
                pos_row = 0;
                band_row = 0;
            end
            else
            begin
                pos_row = pos_row + 1;
                band_row = band_end ? 6'd0 : band_row + 6'd1;
            end
        end
        else
        begin
            pos_col = pos_col + 1;
            if (col_end)
            begin
                blk_col_off = 0;
                blk_col_idx = blk_col_idx + 1;
            end
            else
                blk_col_off = blk_col_off + 1;
        end
        return emit;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 17);
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned k;
        k = $urandom_range(7);
        if (k == 0)
            return 8'd0;
        if (k == 1)
            return 8'd255;
        return 8'($urandom);
    endfunction

    initial
    begin
        clk = 0;
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("mosaic_block_averager_core_tb NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
            hold_left = 400;
        if (hold_left > 0)
        begin
            out_stall = 1;
            hold_left = hold_left - 1;
            if (hold_left == 0)
                hold_request = 0;
        end
        else
            out_stall = idle_now();
    end

    always @(posedge clk)
    begin
        block_avg_t got;
        block_avg_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{avg_red, avg_green, avg_blue, block_row, block_col, pixel_count,
                    last_block};
            blocks_seen++;
            if (pending_blocks.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected block result %p", got);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("block mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, g, b, input bit known);
        block_avg_t res;
        @(negedge clk);
        while (idle_now())
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        red = r;
        green = g;
        blue = b;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pixels_sent++;
        if (average_pixel(r, g, b, res))
        begin
            if (known)
                res = '{r, g, b, 12'd0, 12'd0, 13'd1, 1'b1};
            pending_blocks.push_back(res);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 0;
        wait (pending_blocks.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [12:0] data);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = index;
        cfg_data = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_writes++;
        case (index)
            mba_pkg::REG_BLOCK_SIZE: shadow_bs = data[6:0];
            mba_pkg::REG_IMAGE_WIDTH: shadow_w = data;
            mba_pkg::REG_IMAGE_HEIGHT: shadow_h = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic setup(input logic [12:0] bs, w, h);
        wait_idle();
        write_reg(mba_pkg::REG_BLOCK_SIZE, bs);
        write_reg(mba_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mba_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_images(input int n);
        int total;
        total = clamp_cfg(shadow_w, mba_pkg::MAX_WIDTH) *
                clamp_cfg(shadow_h, mba_pkg::MAX_HEIGHT) * n;
        repeat (total) send_pixel(pick_byte(), pick_byte(), pick_byte(), 0);
    endtask

    initial
    begin
        stim_row_t table_rows[$];
        int phase;
        int k;
        logic [12:0] bs;
        logic [12:0] w;
        logic [12:0] h;
        rst_n = 0;
        in_valid = 0;
        red = 0;
        green = 0;
        blue = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        out_stall = 0;
        shadow_bs = 1;
        shadow_w = 1;
        shadow_h = 1;
        pos_col = 0;
        pos_row = 0;
        band_row = 0;
        blk_col_off = 0;
        blk_col_idx = 0;
        for (int i = 0; i < mba_pkg::MAX_WIDTH; i++)
        begin
            col_sum_r[i] = 0;
            col_sum_g[i] = 0;
            col_sum_b[i] = 0;
        end
        // After reset every image is one pixel, so each pixel is its own block.
        table_rows = '{
            '{1'b0, 2'd0, 13'd0, 8'd0,   8'd0,   8'd0,   1'b1},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd0,   8'd170, 1'b1},
            '{1'b0, 2'd0, 13'd0, 8'd85,  8'd255, 8'd0,   1'b1},
            '{1'b1, mba_pkg::REG_BLOCK_SIZE,   13'd0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b1, mba_pkg::REG_IMAGE_WIDTH,  13'd0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b1, mba_pkg::REG_IMAGE_HEIGHT, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd1,   8'd128, 8'd254, 1'b1},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1},
            '{1'b1, mba_pkg::REG_BLOCK_SIZE,   13'd2, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b1, mba_pkg::REG_IMAGE_WIDTH,  13'd3, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b1, mba_pkg::REG_IMAGE_HEIGHT, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd254, 8'd0,   1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd10,  8'd20,  8'd30,  1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd255, 8'd1,   8'd255, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd254, 8'd0,   8'd7,   1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd3,   8'd99,  8'd200, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd0,   8'd0,   8'd255, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd128, 8'd128, 8'd128, 1'b0},
            '{1'b0, 2'd0, 13'd0, 8'd77,  8'd0,   8'd255, 1'b0}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        foreach (table_rows[i])
        begin
            if (table_rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(table_rows[i].index, table_rows[i].data);
            end
            else
                send_pixel(table_rows[i].red, table_rows[i].green, table_rows[i].blue,
                           table_rows[i].known);
        end

        // Extreme settings: oversized block register, full-size blocks, tall column.
        wait_idle();
        write_reg(REG_SPARE, 13'($urandom));
        setup(13'd127, 13'd70, 13'd2);
        send_images(1);
        setup(13'd64, 13'd1, 13'd66);
        send_images(1);

        phase = 0;
        while (pixels_sent < ITEM_BUDGET || phase < 3)
        begin
            k = $urandom_range(9);
            bs = (k == 0) ? 13'd0 : (k == 1) ? 13'd64 : 13'($urandom_range(1, 8));
            w = (k == 2) ? 13'd0 : 13'($urandom_range(1, 30));
            h = (k == 3) ? 13'd0 : 13'($urandom_range(1, 16));
            setup(bs, w, h);
            calm = (phase == 2);
            if (phase == 1)
                hold_request = 1;
            send_images($urandom_range(1, 2));
            phase++;
        end
        calm = 0;
        wait_idle();
        $display("run covered %0d pixel items in %0d random phases, %0d register writes",
                 pixels_sent, phase, cfg_writes);
        $display("%0d block results checked, %0d mismatches", blocks_seen, errors);
        if (errors == 0)
            $display("mosaic_block_averager_core_tb OK");
        else
            $display("mosaic_block_averager_core_tb NOT OK");
        $finish;
    end
endmodule
